/* rtl/modinv_pkg.sv */
// Shared types and constants for the modular inverse core.
`timescale 1ns / 1ps
package modinv_pkg;

    localparam int FIELD_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_MOD_INIT,
        S_MOD_DIV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic eu_init;
        logic mod_init;
        logic step;
        logic update;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic rc_zero;
        logic cnt_last;
        logic inv_ok;
    } t_status;

endpackage

/* rtl/modinv_in_if.sv */
// Input channel: operand and modulus with valid/ready.
`timescale 1ns / 1ps
interface modinv_in_if;
    logic                          valid;
    logic                          ready;
    logic [modinv_pkg::FIELD_W-1:0] operand_value;
    logic [modinv_pkg::FIELD_W-1:0] modulus;

    modport source (output valid, output operand_value, output modulus, input ready);
    modport sink (input valid, input operand_value, input modulus, output ready);
endinterface

/* rtl/modinv_out_if.sv */
// Output channel: inverse, exists flag and gcd with valid/ready.
`timescale 1ns / 1ps
interface modinv_out_if;
    logic                          valid;
    logic                          ready;
    logic [modinv_pkg::FIELD_W-1:0] inverse;
    logic                          exists;
    logic [modinv_pkg::FIELD_W-1:0] common_divisor;

    modport source (output valid, output inverse, output exists, output common_divisor,
                    input ready);
    modport sink (input valid, input inverse, input exists, input common_divisor,
                  output ready);
endinterface

/* rtl/modinv_dp.sv */
// Datapath: Euclid registers, bit-serial restoring divider, result registers.
`timescale 1ns / 1ps
module modinv_dp #(
    parameter int WIDTH = 32
) (
    input  logic                           i_clk,
    input  modinv_pkg::t_cmd               i_cmd,
    input  logic [modinv_pkg::FIELD_W-1:0] i_operand_value,
    input  logic [modinv_pkg::FIELD_W-1:0] i_modulus,
    output modinv_pkg::t_status            o_status,
    output logic [modinv_pkg::FIELD_W-1:0] o_inverse,
    output logic                           o_exists,
    output logic [modinv_pkg::FIELD_W-1:0] o_common_divisor
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam int FW    = modinv_pkg::FIELD_W;

    logic [WIDTH-1:0] a_w, m_w;
    logic [WIDTH-1:0] r_rp, r_rc, r_sp, r_sc, r_m;
    logic             r_par;
    logic [WIDTH-1:0] r_dvd, r_dvs, r_rem, r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH:0]   trial, diff;
    logic             qbit;
    logic [WIDTH-1:0] n_rem, n_acc;
    logic             inv_ok;
    logic [WIDTH-1:0] inv_w;
    logic [FW-1:0]    inv_f, gcd_f;
    logic [FW-1:0]    r_inverse, r_gcd;
    logic             r_exists;

    generate
        if (WIDTH > FW) begin : g_wide
            assign a_w   = {{(WIDTH-FW){1'b0}}, i_operand_value};
            assign m_w   = {{(WIDTH-FW){1'b0}}, i_modulus};
            assign inv_f = inv_w[FW-1:0];
            assign gcd_f = r_rp[FW-1:0];
        end else if (WIDTH == FW) begin : g_equal
            assign a_w   = i_operand_value;
            assign m_w   = i_modulus;
            assign inv_f = inv_w;
            assign gcd_f = r_rp;
        end else begin : g_narrow
            assign a_w   = i_operand_value[WIDTH-1:0];
            assign m_w   = i_modulus[WIDTH-1:0];
            assign inv_f = {{(FW-WIDTH){1'b0}}, inv_w};
            assign gcd_f = {{(FW-WIDTH){1'b0}}, r_rp};
        end
    endgenerate

    // One quotient bit per cycle; acc builds q * s_cur MSB first.
    always_comb begin
        trial = {r_rem, r_dvd[WIDTH-1]};
        diff  = trial - {1'b0, r_dvs};
        qbit  = ~diff[WIDTH];
        n_rem = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        n_acc = {r_acc[WIDTH-2:0], 1'b0} + (qbit ? r_sc : '0);
    end

    assign inv_ok = (r_m != '0) && (r_rp == WIDTH'(1));

    always_comb begin
        if (!inv_ok) begin
            inv_w = '0;
        end else if (r_par && (r_rem != '0)) begin
            inv_w = r_m - r_rem;
        end else begin
            inv_w = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rp  <= a_w;
            r_rc  <= m_w;
            r_m   <= m_w;
            r_sp  <= WIDTH'(1);
            r_sc  <= '0;
            r_par <= 1'b0;
        end
        if (i_cmd.update) begin
            r_rp  <= r_rc;
            r_rc  <= r_rem;
            r_sp  <= r_sc;
            r_sc  <= r_sp + r_acc;
            r_par <= ~r_par;
        end
        if (i_cmd.eu_init || i_cmd.mod_init) begin
            r_dvd <= i_cmd.eu_init ? r_rp : r_sp;
            r_dvs <= i_cmd.eu_init ? r_rc : r_m;
            r_rem <= '0;
            r_acc <= '0;
            r_cnt <= CNT_W'(WIDTH - 1);
        end
        if (i_cmd.step) begin
            r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.finish) begin
            r_inverse <= inv_f;
            r_exists  <= inv_ok;
            r_gcd     <= gcd_f;
        end
    end

    assign o_status.rc_zero  = (r_rc == '0);
    assign o_status.cnt_last = (r_cnt == '0);
    assign o_status.inv_ok   = inv_ok;

    assign o_inverse        = r_inverse;
    assign o_exists         = r_exists;
    assign o_common_divisor = r_gcd;

endmodule

/* rtl/modinv_ctrl.sv */
// Controller: sequences Euclid steps, final reduction and output handshake.
`timescale 1ns / 1ps
module modinv_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  modinv_pkg::t_status i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output modinv_pkg::t_cmd    o_cmd
);

    modinv_pkg::t_state r_state, n_state;
    logic               r_out_valid;
    logic               out_free;

    assign out_free = ~r_out_valid | i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            modinv_pkg::S_IDLE: begin
                if (i_in_valid) n_state = modinv_pkg::S_CHECK;
            end
            modinv_pkg::S_CHECK: begin
                n_state = i_status.rc_zero ? modinv_pkg::S_MOD_INIT : modinv_pkg::S_DIV;
            end
            modinv_pkg::S_DIV: begin
                if (i_status.cnt_last) n_state = modinv_pkg::S_UPDATE;
            end
            modinv_pkg::S_UPDATE: begin
                n_state = modinv_pkg::S_CHECK;
            end
            modinv_pkg::S_MOD_INIT: begin
                n_state = i_status.inv_ok ? modinv_pkg::S_MOD_DIV : modinv_pkg::S_FINISH;
            end
            modinv_pkg::S_MOD_DIV: begin
                if (i_status.cnt_last) n_state = modinv_pkg::S_FINISH;
            end
            modinv_pkg::S_FINISH: begin
                if (out_free) n_state = modinv_pkg::S_IDLE;
            end
            default: begin
                n_state = modinv_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            modinv_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            modinv_pkg::S_CHECK: begin
                o_cmd.eu_init = ~i_status.rc_zero;
            end
            modinv_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
            end
            modinv_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            modinv_pkg::S_MOD_INIT: begin
                o_cmd.mod_init = i_status.inv_ok;
            end
            modinv_pkg::S_MOD_DIV: begin
                o_cmd.step = 1'b1;
            end
            modinv_pkg::S_FINISH: begin
                o_cmd.finish = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= modinv_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/modular_inverse_core.sv */
// Top level of the modular inverse core (extended Euclid).
//
// Channels: i_in takes an item of operand_value and modulus; o_out returns
// one item per input with inverse, exists and common_divisor. Both follow
// valid/ready; an item moves on a rising edge with valid and ready high.
// The block works on one item at a time. Each Euclid step is a check, a
// pass of the bit-serial restoring divider and an update. The last check
// finds a zero remainder; if the gcd is one and m is nonzero, the final
// reduction of the coefficient modulo m then runs on the same divider.
// The finish state loads the result register, and idle takes the next
// item. The shared divider sets the time from accept to accept.
// The result sits in an output register, so the next item is accepted while
// the previous result waits. If the receiver stalls and the next result is
// ready, the block holds in its finish state until the register frees.
// Reset (synchronous, active low) returns the controller to idle and drops
// output valid; no memory needs clearing.
`timescale 1ns / 1ps
module modular_inverse_core #(
    parameter int WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    modinv_in_if.sink           i_in,
    modinv_out_if.source        o_out
);

    modinv_pkg::t_cmd    cmd;
    modinv_pkg::t_status status;
    logic                in_ready;
    logic                out_valid;

    modinv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    modinv_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_operand_value  (i_in.operand_value),
        .i_modulus        (i_in.modulus),
        .o_status         (status),
        .o_inverse        (o_out.inverse),
        .o_exists         (o_out.exists),
        .o_common_divisor (o_out.common_divisor)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    a_cmd_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready) |=> !in_ready)
        else $error("input ready while an item is in progress");

    a_exists_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && o_out.exists) |-> (o_out.common_divisor == 32'd1))
        else $error("inverse flagged with gcd other than one");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !o_out.exists) |-> (o_out.inverse == '0))
        else $error("nonzero inverse without an inverse");

endmodule

/* sim/modular_inverse_core_checker.sv */
// Result checker for the modular inverse core: predicts each result and compares.
`timescale 1ns / 1ps
module modular_inverse_core_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    modinv_in_if  i_in,
    modinv_out_if i_out,
    output int    o_errors,
    output int    o_pending,
    output int    o_checked,
    output int    o_invertible
);

    typedef struct packed {
        logic [modinv_pkg::FIELD_W-1:0] inverse;
        logic                           exists;
        logic [modinv_pkg::FIELD_W-1:0] common_divisor;
    } t_inverse_result;

    t_inverse_result expected_inverses[$];

    function automatic t_inverse_result predict_inverse(
        input logic [modinv_pkg::FIELD_W-1:0] a,
        input logic [modinv_pkg::FIELD_W-1:0] m
    );
        t_inverse_result                res;
        logic [modinv_pkg::FIELD_W-1:0] r_prev, r_cur, r_next, quot;
        logic [modinv_pkg::FIELD_W-1:0] s_prev, s_cur, s_next, mag;
        logic [63:0]                    prod;
        logic                           odd_step;
        r_prev   = a;
        r_cur    = m;
        s_prev   = 1;
        s_cur    = 0;
        odd_step = 1'b0;
        while (r_cur != 0) begin
            quot     = r_prev / r_cur;
            r_next   = r_prev - quot * r_cur;
            prod     = {32'b0, quot} * {32'b0, s_cur};
            s_next   = s_prev + prod[modinv_pkg::FIELD_W-1:0];
            r_prev   = r_cur;
            r_cur    = r_next;
            s_prev   = s_cur;
            s_cur    = s_next;
            odd_step = ~odd_step;
        end
        res.inverse        = '0;
        res.exists         = 1'b0;
        res.common_divisor = r_prev;
        if (m != 0 && r_prev == 1) begin
            mag        = s_prev % m;
            res.exists = 1'b1;
            // coefficient sign alternates with the step count
            res.inverse = (odd_step && mag != 0) ? m - mag : mag;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_inverse_result want;
        t_inverse_result got;
        if (!i_rst_n) begin
            expected_inverses.delete();
            o_errors     <= 0;
            o_pending    <= 0;
            o_checked    <= 0;
            o_invertible <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.inverse        = i_out.inverse;
                got.exists         = i_out.exists;
                got.common_divisor = i_out.common_divisor;
                if (expected_inverses.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected result inv=%h exists=%b gcd=%h", $time,
                                 got.inverse, got.exists, got.common_divisor);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_inverses.pop_front();
                    o_checked <= o_checked + 1;
                    if (want.exists)
                        o_invertible <= o_invertible + 1;
                    if (got.inverse !== want.inverse || got.exists !== want.exists ||
                        got.common_divisor !== want.common_divisor) begin
                        if (o_errors < 10)
                            $display("%0t: exp inv=%h ex=%b gcd=%h, got inv=%h ex=%b gcd=%h",
                                     $time, want.inverse, want.exists, want.common_divisor,
                                     got.inverse, got.exists, got.common_divisor);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                expected_inverses.push_back(predict_inverse(i_in.operand_value, i_in.modulus));
            o_pending <= expected_inverses.size();
        end
    end

endmodule

/* sim/modular_inverse_core_tb.sv */
// Testbench top for the modular inverse core: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module modular_inverse_core_tb;

    localparam int N_DIRECTED = 23;
    localparam int N_PER_PHASE = 375;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int errors, pending, checked, invertible;
    int send_idle_pct, recv_stall_pct;
    int items_sent;
    int pct_send [4] = '{0, 62, 0, 34};
    int pct_recv [4] = '{0, 0, 62, 34};

    modinv_in_if  in_ch ();
    modinv_out_if out_ch ();

    modular_inverse_core #(.WIDTH(modinv_pkg::FIELD_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    modular_inverse_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_invertible (invertible)
    );

    logic [modinv_pkg::FIELD_W-1:0] dir_operand [N_DIRECTED] = '{
        32'd0, 32'd5, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0,
        32'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3, 32'd10, 32'd12,
        32'd10, 32'h8000_0000, 32'hFFFF_FFFF, 32'd2971215073, 32'd1836311903,
        32'd17, 32'd2, 32'd4294967291
    };
    logic [modinv_pkg::FIELD_W-1:0] dir_modulus [N_DIRECTED] = '{
        32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1, 32'd7, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd7, 32'd7,
        32'd18, 32'd4, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1836311903, 32'd2971215073,
        32'd4294967291, 32'd4, 32'd65537
    };

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk)
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);

    task automatic send_item(input logic [modinv_pkg::FIELD_W-1:0] a,
                             input logic [modinv_pkg::FIELD_W-1:0] m);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.operand_value = a;
        in_ch.modulus       = m;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        logic [modinv_pkg::FIELD_W-1:0] a, m, g;
        int pick;
        pick = $urandom_range(99);
        a    = $urandom();
        m    = $urandom();
        if (pick < 20) begin
            m[0] = 1'b1;
        end else if (pick < 35) begin
            a = $urandom_range(255);
            m = $urandom_range(255);
        end else if (pick < 45) begin
            m = $urandom_range(1, 65535);
        end else if (pick < 55) begin
            g = $urandom_range(2, 65535);
            a = g * $urandom_range(65535);
            m = g * $urandom_range(1, 65535);
        end else if (pick < 60) begin
            case ($urandom_range(3))
                0: m = 0;
                1: m = 1;
                2: a = 0;
                default: m = '1;
            endcase
        end
        send_item(a, m);
    endtask

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.operand_value = '0;
        in_ch.modulus       = '0;
        out_ch.ready        = 1'b0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        items_sent          = 0;
        i_rst_n             = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(dir_operand[i], dir_modulus[i]);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = pct_send[ph];
            recv_stall_pct = pct_recv[ph];
            for (int i = 0; i < N_PER_PHASE; i++)
                send_random_item();
        end
        in_ch.valid    = 1'b0;
        recv_stall_pct = 0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d operand/modulus items (%0d directed) over four idle/stall phases.",
                 items_sent, N_DIRECTED);
        $display("Checked %0d results, %0d with an inverse; %0d mismatches.",
                 checked, invertible, errors);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #400ms;
        $display("Timeout with %0d results still outstanding.", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/modinv_pkg.sv
rtl/modinv_in_if.sv
rtl/modinv_out_if.sv
rtl/modinv_dp.sv
rtl/modinv_ctrl.sv
rtl/modular_inverse_core.sv
sim/modular_inverse_core_checker.sv
sim/modular_inverse_core_tb.sv
